FILE: rtl/sts_pkg.sv
// Shared types, token codes and keyword table of the source token scanner.
`timescale 1ns / 1ps
package sts_pkg;

	localparam int KW_COUNT = 21;
	localparam int KW_CHARS = 8;

	localparam logic [5:0] KIND_EOF     = 6'd0;
	localparam logic [5:0] KIND_IDENT   = 6'd1;
	localparam logic [5:0] KIND_NUMBER  = 6'd2;
	localparam logic [5:0] KIND_STRING  = 6'd3;
	localparam logic [5:0] KIND_ERROR   = 6'd4;
	localparam logic [5:0] KIND_PERCENT = 6'd5;
	localparam logic [5:0] KIND_PIPE    = 6'd6;
	localparam logic [5:0] KIND_AMP     = 6'd7;
	localparam logic [5:0] KIND_COLON   = 6'd8;
	localparam logic [5:0] KIND_LPAREN  = 6'd9;
	localparam logic [5:0] KIND_RPAREN  = 6'd10;
	localparam logic [5:0] KIND_LBRACE  = 6'd11;
	localparam logic [5:0] KIND_RBRACE  = 6'd12;
	localparam logic [5:0] KIND_LBRACK  = 6'd13;
	localparam logic [5:0] KIND_RBRACK  = 6'd14;
	localparam logic [5:0] KIND_SEMI    = 6'd15;
	localparam logic [5:0] KIND_COMMA   = 6'd16;
	localparam logic [5:0] KIND_DOT     = 6'd17;
	localparam logic [5:0] KIND_MINUS   = 6'd18;
	localparam logic [5:0] KIND_PLUS    = 6'd19;
	localparam logic [5:0] KIND_SLASH   = 6'd20;
	localparam logic [5:0] KIND_STAR    = 6'd21;
	localparam logic [5:0] KIND_BANG    = 6'd22;
	localparam logic [5:0] KIND_BANG_EQ = 6'd23;
	localparam logic [5:0] KIND_EQ      = 6'd24;
	localparam logic [5:0] KIND_EQ_EQ   = 6'd25;
	localparam logic [5:0] KIND_LT      = 6'd26;
	localparam logic [5:0] KIND_LT_EQ   = 6'd27;
	localparam logic [5:0] KIND_SHL     = 6'd28;
	localparam logic [5:0] KIND_GT      = 6'd29;
	localparam logic [5:0] KIND_GT_EQ   = 6'd30;
	localparam logic [5:0] KIND_SHR     = 6'd31;
	localparam logic [5:0] KIND_KW_BASE = 6'd32;

	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_UNEXP    = 2'd1;
	localparam logic [1:0] ERR_STRING   = 2'd2;
	localparam logic [1:0] ERR_NUM_EOF  = 2'd3;

	// keyword text, first character in the top byte, zero padded
	localparam logic [63:0] KW_TXT [KW_COUNT] = '{
		{"and", 40'd0}, {"else", 32'd0}, {"const", 24'd0}, {"if", 48'd0},
		{"inline", 16'd0}, {"nil", 40'd0}, {"or", 48'd0}, {"parallel"},
		{"print", 24'd0}, {"pub", 40'd0}, {"len", 40'd0}, {"return", 16'd0},
		{"struct", 16'd0}, {"sync", 32'd0}, {"var", 40'd0}, {"while", 24'd0},
		{"use", 40'd0}, {"true", 32'd0}, {"false", 24'd0}, {"for", 40'd0},
		{"fun", 40'd0}
	};
	localparam logic [3:0] KW_LEN [KW_COUNT] = '{
		4'd3, 4'd4, 4'd5, 4'd2, 4'd6, 4'd3, 4'd2, 4'd8, 4'd5, 4'd3, 4'd3,
		4'd6, 4'd6, 4'd4, 4'd3, 4'd5, 4'd3, 4'd4, 4'd5, 4'd3, 4'd3
	};

	typedef struct packed {
		logic [5:0]  token_kind;
		logic [15:0] token_start;
		logic [15:0] token_length;
		logic [15:0] token_line;
		logic [1:0]  error_code;
		logic        last_of_run;
	} token_t;

	typedef struct packed {
		logic [1:0] n;
		token_t     t0;
		token_t     t1;
		token_t     t2;
	} bundle_t;

	function automatic logic [15:0] sat_inc(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	// word is packed first character on top; len counts valid characters
	function automatic logic [5:0] kw_kind(input logic [63:0] word, input logic [15:0] len);
		logic [5:0]  k;
		logic [63:0] mask;
		k = KIND_IDENT;
		mask = ~({64{1'b1}} >> (7'(len[3:0]) * 7'd8));
		if (len <= 16'(KW_CHARS) && len != 16'd0) begin
			for (int i = 0; i < KW_COUNT; i++) begin
				if (16'(KW_LEN[i]) == len && (word & mask) == KW_TXT[i])
					k = KIND_KW_BASE + 6'(i);
			end
		end
		return k;
	endfunction

endpackage

FILE: rtl/sts_if.sv
// Valid/ready channel interfaces for source bytes and tokens.
`timescale 1ns / 1ps
interface sts_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] source_byte;
	modport source (output valid, output source_byte, input ready);
	modport sink (input valid, input source_byte, output ready);
endinterface

interface sts_tok_if;
	logic        valid;
	logic        ready;
	logic [5:0]  token_kind;
	logic [15:0] token_start;
	logic [15:0] token_length;
	logic [15:0] token_line;
	logic [1:0]  error_code;
	logic        last_of_run;
	modport source (output valid, output token_kind, output token_start, output token_length,
		output token_line, output error_code, output last_of_run, input ready);
	modport sink (input valid, input token_kind, input token_start, input token_length,
		input token_line, input error_code, input last_of_run, output ready);
endinterface

FILE: rtl/source_token_scanner_unit.sv
// Top level of the source token scanner: byte channel in, token channel out.
// The byte that ends a token waits in the input register, then its tokens wait in the result register.
// Throughput: one byte per cycle while each byte gives at most one token and the token
// output is ready; a byte that gives two or three tokens holds the input until its last
// token is taken at the single token output port.
// Reset: asynchronous, clears scanner state, counters and queued tokens.
`timescale 1ns / 1ps
module source_token_scanner_unit #(
	parameter int POSITION_BITS = 16
) (
	input logic      clk,
	input logic      arst_n,
	sts_byte_if.sink src,
	sts_tok_if.source tok
);

	sts_pkg::bundle_t bundle;
	logic             fire, take;

	sts_scan #(.POSITION_BITS(POSITION_BITS)) u_scan (
		.clk(clk), .arst_n(arst_n), .src(src), .take(take), .fire(fire), .bundle(bundle)
	);

	sts_emit u_emit (
		.clk(clk), .arst_n(arst_n), .fire(fire), .bundle(bundle), .take(take), .tok(tok)
	);

endmodule

FILE: rtl/sts_scan.sv
// Input register and scanner state step: one byte in, up to three tokens out.
`timescale 1ns / 1ps
module sts_scan #(
	parameter int POSITION_BITS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	sts_byte_if.sink        src,
	input  logic            take,
	output logic            fire,
	output sts_pkg::bundle_t bundle
);

	typedef enum logic [11:0] {
		M_IDLE    = 12'b0000_0000_0001,
		M_COMMENT = 12'b0000_0000_0010,
		M_SLASH   = 12'b0000_0000_0100,
		M_IDENT   = 12'b0000_0000_1000,
		M_INT     = 12'b0000_0001_0000,
		M_DOT     = 12'b0000_0010_0000,
		M_FRAC    = 12'b0000_0100_0000,
		M_STRING  = 12'b0000_1000_0000,
		M_BANG    = 12'b0001_0000_0000,
		M_EQUAL   = 12'b0010_0000_0000,
		M_LESS    = 12'b0100_0000_0000,
		M_GREATER = 12'b1000_0000_0000
	} mode_t;

	typedef struct packed {
		mode_t      mode;
		logic       emit;
		logic [5:0] kind;
		logic       err;
		logic       nl;
		logic       alpha;
	} start_t;

	localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

	logic [7:0]               byte_s1;
	logic                     valid_s1;
	mode_t                    mode_q, mode_d;
	logic [POSITION_BITS-1:0] pos_q, pos_d, begin_q, begin_d, pdot_q, pdot_d;
	logic [15:0]              line_q, line_d, len_q, len_d;
	logic [7:0]               pre_q [sts_pkg::KW_CHARS];
	logic                     pre_we;
	logic [2:0]               pre_idx;
	logic [63:0]              word;
	start_t                   st;
	sts_pkg::token_t          ta, tb, tc;
	logic                     va, vb, vc;
	logic [7:0]               c;
	logic                     dig, alnum;

	function automatic logic chr_num(input logic [7:0] x);
		return x >= "0" && x <= "9";
	endfunction

	function automatic logic chr_letter(input logic [7:0] x);
		return (x >= "a" && x <= "z") || (x >= "A" && x <= "Z") || x == "_";
	endfunction

	function automatic start_t start_fn(input logic [7:0] x);
		start_t s;
		s = '{mode: M_IDLE, emit: 1'b1, kind: sts_pkg::KIND_ERROR, err: 1'b1, nl: 1'b0,
			alpha: 1'b0};
		if (chr_num(x)) begin
			s.mode = M_INT; s.emit = 1'b0;
		end else if (chr_letter(x)) begin
			s.mode = M_IDENT; s.emit = 1'b0; s.alpha = 1'b1;
		end else begin
			s.err = 1'b0;
			case (x)
				" ", 8'h09, 8'h0D: s.emit = 1'b0;
				8'h0A: begin s.emit = 1'b0; s.nl = 1'b1; end
				"/": begin s.emit = 1'b0; s.mode = M_SLASH; end
				8'h22: begin s.emit = 1'b0; s.mode = M_STRING; end
				"!": begin s.emit = 1'b0; s.mode = M_BANG; end
				"=": begin s.emit = 1'b0; s.mode = M_EQUAL; end
				"<": begin s.emit = 1'b0; s.mode = M_LESS; end
				">": begin s.emit = 1'b0; s.mode = M_GREATER; end
				"%": s.kind = sts_pkg::KIND_PERCENT;
				"|": s.kind = sts_pkg::KIND_PIPE;
				"&": s.kind = sts_pkg::KIND_AMP;
				":": s.kind = sts_pkg::KIND_COLON;
				"(": s.kind = sts_pkg::KIND_LPAREN;
				")": s.kind = sts_pkg::KIND_RPAREN;
				"{": s.kind = sts_pkg::KIND_LBRACE;
				"}": s.kind = sts_pkg::KIND_RBRACE;
				"[": s.kind = sts_pkg::KIND_LBRACK;
				"]": s.kind = sts_pkg::KIND_RBRACK;
				";": s.kind = sts_pkg::KIND_SEMI;
				",": s.kind = sts_pkg::KIND_COMMA;
				".": s.kind = sts_pkg::KIND_DOT;
				"-": s.kind = sts_pkg::KIND_MINUS;
				"+": s.kind = sts_pkg::KIND_PLUS;
				"*": s.kind = sts_pkg::KIND_STAR;
				default: s.err = 1'b1;
			endcase
		end
		return s;
	endfunction

	function automatic sts_pkg::token_t mk(input logic [5:0] k, input logic [15:0] s,
		input logic [15:0] l, input logic [15:0] ln, input logic [1:0] e);
		sts_pkg::token_t t;
		t.token_kind = k; t.token_start = s; t.token_length = l;
		t.token_line = ln; t.error_code = e; t.last_of_run = 1'b0;
		return t;
	endfunction

	assign c     = byte_s1;
	assign dig   = chr_num(c);
	assign alnum = dig || chr_letter(c);
	assign st    = start_fn(c);
	assign word  = {pre_q[0], pre_q[1], pre_q[2], pre_q[3],
		pre_q[4], pre_q[5], pre_q[6], pre_q[7]};

	always_comb begin
		logic       do_start;
		logic [5:0] k2;
		logic       hit;
		do_start = 1'b0;
		k2 = sts_pkg::KIND_BANG;
		hit = 1'b0;
		mode_d = mode_q; begin_d = begin_q; pdot_d = pdot_q;
		line_d = line_q; len_d = len_q;
		pos_d = (pos_q < POS_MAX) ? pos_q + 1'b1 : pos_q;
		pre_we = 1'b0; pre_idx = len_q[2:0];
		va = 1'b0; vb = 1'b0; vc = 1'b0;
		ta = mk(sts_pkg::KIND_SLASH, 16'(begin_q), len_q, line_q, sts_pkg::ERR_NONE);
		tb = mk(sts_pkg::KIND_DOT, 16'(pdot_q), 16'd1, line_q, sts_pkg::ERR_NONE);
		tc = mk(sts_pkg::KIND_EOF, 16'(pos_q), 16'd0, line_q, sts_pkg::ERR_NONE);
		if (c == 8'd0) begin
			vc = 1'b1;
			case (mode_q)
				M_SLASH: va = 1'b1;
				M_IDENT: begin va = 1'b1; ta.token_kind = sts_pkg::kw_kind(word, len_q); end
				M_INT, M_FRAC: begin
					va = 1'b1;
					ta = mk(sts_pkg::KIND_ERROR, 16'd0, 16'd0, line_q, sts_pkg::ERR_NUM_EOF);
				end
				M_DOT: begin va = 1'b1; vb = 1'b1; ta.token_kind = sts_pkg::KIND_NUMBER; end
				M_STRING: begin
					va = 1'b1;
					ta = mk(sts_pkg::KIND_ERROR, 16'd0, 16'd0, line_q, sts_pkg::ERR_STRING);
				end
				M_BANG: begin va = 1'b1; ta.token_kind = sts_pkg::KIND_BANG; end
				M_EQUAL: begin va = 1'b1; ta.token_kind = sts_pkg::KIND_EQ; end
				M_LESS: begin va = 1'b1; ta.token_kind = sts_pkg::KIND_LT; end
				M_GREATER: begin va = 1'b1; ta.token_kind = sts_pkg::KIND_GT; end
				default: ;
			endcase
			mode_d = M_IDLE; pos_d = '0; begin_d = '0; line_d = '0; pdot_d = '0;
			len_d = '0;
		end else begin
			case (mode_q)
				M_COMMENT: if (c == 8'h0A) begin line_d = sts_pkg::sat_inc(line_q); mode_d = M_IDLE; end
				M_SLASH: begin
					if (c == "/") mode_d = M_COMMENT;
					else begin va = 1'b1; do_start = 1'b1; end
				end
				M_IDENT: begin
					if (alnum) begin
						pre_we = len_q < 16'(sts_pkg::KW_CHARS);
						len_d = sts_pkg::sat_inc(len_q);
					end else begin
						va = 1'b1; ta.token_kind = sts_pkg::kw_kind(word, len_q); do_start = 1'b1;
					end
				end
				M_INT: begin
					if (dig) len_d = sts_pkg::sat_inc(len_q);
					else if (c == ".") begin pdot_d = pos_q; mode_d = M_DOT; end
					else begin va = 1'b1; ta.token_kind = sts_pkg::KIND_NUMBER; do_start = 1'b1; end
				end
				M_DOT: begin
					if (dig) begin
						len_d = sts_pkg::sat_inc(sts_pkg::sat_inc(len_q)); mode_d = M_FRAC;
					end else begin
						va = 1'b1; vb = 1'b1; ta.token_kind = sts_pkg::KIND_NUMBER; do_start = 1'b1;
					end
				end
				M_FRAC: begin
					if (dig) len_d = sts_pkg::sat_inc(len_q);
					else begin va = 1'b1; ta.token_kind = sts_pkg::KIND_NUMBER; do_start = 1'b1; end
				end
				M_STRING: begin
					len_d = sts_pkg::sat_inc(len_q);
					if (c == 8'h22) begin
						va = 1'b1; ta.token_kind = sts_pkg::KIND_STRING;
						ta.token_length = len_d; mode_d = M_IDLE;
					end else if (c == 8'h0A) line_d = sts_pkg::sat_inc(line_q);
				end
				M_BANG, M_EQUAL, M_LESS, M_GREATER: begin
					va = 1'b1;
					case (mode_q)
						M_BANG: begin
							ta.token_kind = sts_pkg::KIND_BANG;
							hit = c == "="; k2 = sts_pkg::KIND_BANG_EQ;
						end
						M_EQUAL: begin
							ta.token_kind = sts_pkg::KIND_EQ;
							hit = c == "="; k2 = sts_pkg::KIND_EQ_EQ;
						end
						M_LESS: begin
							ta.token_kind = sts_pkg::KIND_LT;
							hit = c == "=" || c == "<";
							k2 = (c == "=") ? sts_pkg::KIND_LT_EQ : sts_pkg::KIND_SHL;
						end
						default: begin
							ta.token_kind = sts_pkg::KIND_GT;
							hit = c == "=" || c == ">";
							k2 = (c == "=") ? sts_pkg::KIND_GT_EQ : sts_pkg::KIND_SHR;
						end
					endcase
					if (hit) begin
						ta.token_kind = k2; ta.token_length = 16'd2;
						len_d = 16'd2; mode_d = M_IDLE;
					end else do_start = 1'b1;
				end
				default: do_start = 1'b1;
			endcase
			if (do_start) begin
				begin_d = pos_q; len_d = 16'd1; mode_d = st.mode;
				if (st.nl) line_d = sts_pkg::sat_inc(line_q);
				if (st.alpha) begin pre_we = 1'b1; pre_idx = 3'd0; end
				vc = st.emit;
				tc = st.err
					? mk(sts_pkg::KIND_ERROR, 16'd0, 16'd0, line_q, sts_pkg::ERR_UNEXP)
					: mk(st.kind, 16'(pos_q), 16'd1, line_q, sts_pkg::ERR_NONE);
			end
		end
		ta.last_of_run = !vb && !vc;
		tb.last_of_run = !vc;
		tc.last_of_run = 1'b1;
		bundle.n  = 2'(va) + 2'(vb) + 2'(vc);
		bundle.t0 = va ? ta : tc;
		bundle.t1 = vb ? tb : tc;
		bundle.t2 = tc;
	end

	// an item with no tokens needs no room in the emitter
	assign fire      = valid_s1 && (take || bundle.n == 2'd0);
	assign src.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mode_q   <= M_IDLE;
			pos_q    <= '0;
			begin_q  <= '0;
			pdot_q   <= '0;
			line_q   <= '0;
			len_q    <= '0;
		end else begin
			if (src.ready) valid_s1 <= src.valid;
			if (fire) begin
				mode_q  <= mode_d;
				pos_q   <= pos_d;
				begin_q <= begin_d;
				pdot_q  <= pdot_d;
				line_q  <= line_d;
				len_q   <= len_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (src.ready && src.valid) byte_s1 <= src.source_byte;
		if (fire && pre_we) pre_q[pre_idx] <= c;
	end

endmodule

FILE: rtl/sts_emit.sv
// Result register: holds one byte's tokens and hands them out one per cycle while the sink is ready.
`timescale 1ns / 1ps
module sts_emit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  sts_pkg::bundle_t bundle,
	output logic             take,
	sts_tok_if.source        tok
);

	logic [1:0]      cnt_q;
	sts_pkg::token_t slot0_q, slot1_q, slot2_q;
	logic            hs, load;

	assign hs   = tok.valid && tok.ready;
	assign take = cnt_q == 2'd0 || (hs && cnt_q == 2'd1);
	assign load = fire && bundle.n != 2'd0;

	assign tok.valid        = cnt_q != 2'd0;
	assign tok.token_kind   = slot0_q.token_kind;
	assign tok.token_start  = slot0_q.token_start;
	assign tok.token_length = slot0_q.token_length;
	assign tok.token_line   = slot0_q.token_line;
	assign tok.error_code   = slot0_q.error_code;
	assign tok.last_of_run  = slot0_q.last_of_run;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= bundle.n;
		end else if (hs) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot0_q <= bundle.t0;
			slot1_q <= bundle.t1;
			slot2_q <= bundle.t2;
		end else if (hs) begin
			slot0_q <= slot1_q;
			slot1_q <= slot2_q;
		end
	end

`ifndef SYNTHESIS
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		tok.valid |-> (tok.last_of_run == (cnt_q == 2'd1)))
		else $error("last_of_run out of step with queued tokens");
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		hs && cnt_q == 2'd1 && !load |=> !tok.valid)
		else $error("token shown after final one was taken");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> take)
		else $error("new tokens loaded over pending ones");
`endif

endmodule
